// File: rtl/core/gbs_pkg.sv
// Shared widths, payload structures and control state codes for box suppression.
`default_nettype none
package gbs_pkg;

   localparam int COORD_W = 16;
   localparam int SIZE_W  = 15;
   localparam int AREA_W  = 30;
   localparam int THR_W   = 9;
   localparam int COUNT_W = 7;

   localparam logic [THR_W-1:0] THR_RESET = 9'd128;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [SIZE_W-1:0]         width;
      logic [SIZE_W-1:0]         height;
   } box_type;

   // box travelling down the cell row
   typedef struct packed {
      logic              live;
      logic              sup;
      box_type           box;
      logic [AREA_W-1:0] area;
   } word_type;

   // append of a kept box into one cell
   typedef struct packed {
      logic              en;
      box_type           box;
      logic [AREA_W-1:0] area;
   } wr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

// File: rtl/core/gbs_channels.sv
// Handshake channel interfaces for box requests, results and the threshold register.
`default_nettype none
interface gbs_req_if;
   logic                                valid;
   logic                                ready;
   logic                                first_of_frame;
   logic signed [gbs_pkg::COORD_W-1:0]  box_x;
   logic signed [gbs_pkg::COORD_W-1:0]  box_y;
   logic [gbs_pkg::SIZE_W-1:0]          box_width;
   logic [gbs_pkg::SIZE_W-1:0]          box_height;

   modport source (output valid, first_of_frame, box_x, box_y, box_width, box_height,
                   input ready);
   modport sink   (input valid, first_of_frame, box_x, box_y, box_width, box_height,
                   output ready);
endinterface

interface gbs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          keep;
   logic [gbs_pkg::COUNT_W-1:0]   kept_count;
   logic                          overflow;

   modport source (output valid, keep, kept_count, overflow, input ready);
   modport sink   (input valid, keep, kept_count, overflow, output ready);
endinterface

interface gbs_csr_if;
   logic                        valid;
   logic                        ready;
   logic [gbs_pkg::THR_W-1:0]   iou_threshold;

   modport source (output valid, iou_threshold, input ready);
   modport sink   (input valid, iou_threshold, output ready);
endinterface
`default_nettype wire

// File: rtl/core/gbs_cell.sv
// One kept-box slot: stores a box and tests each passing box against it by IoU.
`default_nettype none
module gbs_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 7,
   parameter int IDX_W = 6,
   parameter int FRAC  = 8
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire  [gbs_pkg::THR_W-1:0]        thr,
   input  wire  [CNT_W-1:0]                 count,
   input  gbs_pkg::wr_type                  wr,
   input  wire  [IDX_W-1:0]                 wr_idx,
   input  gbs_pkg::word_type                word_in,
   output gbs_pkg::word_type                word_out
);

   localparam int SUM_W  = gbs_pkg::AREA_W + 1;
   localparam int PROD_W = gbs_pkg::THR_W + SUM_W;
   localparam int CMP_W  = (PROD_W > gbs_pkg::AREA_W + FRAC) ? PROD_W
                                                            : gbs_pkg::AREA_W + FRAC;

   gbs_pkg::box_type              kbox_ff;
   logic [gbs_pkg::AREA_W-1:0]    karea_ff;

   gbs_pkg::word_type             w1_ff, w2_ff, w3_ff, out_ff;
   logic                          act1_ff, act2_ff, act3_ff;
   logic [gbs_pkg::SIZE_W-1:0]    iw1_ff, ih1_ff;
   logic [SUM_W-1:0]              sum1_ff, sum2_ff;
   logic [gbs_pkg::AREA_W-1:0]    inter2_ff, inter3_ff;
   logic [PROD_W-1:0]             prod3_ff;

   logic signed [17:0] ax0, ax1, ay0, ay1, bx0, bx1, by0, by1;
   logic signed [17:0] ixl, ixr, iyt, iyb, iw, ih;
   logic               apart;
   logic [gbs_pkg::SIZE_W-1:0]    iw1_in, ih1_in;
   logic [SUM_W-1:0]              sum1_in;
   logic                          act1_in;
   logic [gbs_pkg::AREA_W-1:0]    inter2_in;
   logic [SUM_W-1:0]              uni3;
   logic [PROD_W-1:0]             prod3_in;
   logic [CMP_W-1:0]              lhs, rhs;
   gbs_pkg::word_type             out_in;

   // extents and overlap widths
   always_comb begin
      ax0 = {{2{word_in.box.x[15]}}, word_in.box.x};
      ay0 = {{2{word_in.box.y[15]}}, word_in.box.y};
      ax1 = ax0 + $signed({3'b000, word_in.box.width});
      ay1 = ay0 + $signed({3'b000, word_in.box.height});
      bx0 = {{2{kbox_ff.x[15]}}, kbox_ff.x};
      by0 = {{2{kbox_ff.y[15]}}, kbox_ff.y};
      bx1 = bx0 + $signed({3'b000, kbox_ff.width});
      by1 = by0 + $signed({3'b000, kbox_ff.height});
      apart = (ax0 > bx1) || (ax1 < bx0) || (ay0 > by1) || (ay1 < by0);
      ixl = (ax0 > bx0) ? ax0 : bx0;
      ixr = (ax1 < bx1) ? ax1 : bx1;
      iyt = (ay0 > by0) ? ay0 : by0;
      iyb = (ay1 < by1) ? ay1 : by1;
      iw  = ixr - ixl;
      ih  = iyb - iyt;
      if (apart || (iw <= 18'sd0) || (ih <= 18'sd0)) begin
         iw1_in = '0;
         ih1_in = '0;
      end else begin
         iw1_in = iw[gbs_pkg::SIZE_W-1:0];
         ih1_in = ih[gbs_pkg::SIZE_W-1:0];
      end
      sum1_in = {1'b0, word_in.area} + {1'b0, karea_ff};
      act1_in = count > CNT_W'(INDEX);
   end

   always_comb begin
      inter2_in = gbs_pkg::AREA_W'(iw1_ff) * gbs_pkg::AREA_W'(ih1_ff);
      uni3      = sum2_ff - {1'b0, inter2_ff};
      prod3_in  = PROD_W'(thr) * PROD_W'(uni3);
      lhs       = CMP_W'(inter3_ff) << FRAC;
      rhs       = CMP_W'(prod3_ff);
      out_in     = w3_ff;
      out_in.sup = w3_ff.sup | (act3_ff & (lhs > rhs));
   end

   always_ff @(posedge clock) begin
      if (wr.en && (wr_idx == IDX_W'(INDEX))) begin
         kbox_ff  <= wr.box;
         karea_ff <= wr.area;
      end
      act1_ff   <= act1_in;
      act2_ff   <= act1_ff;
      act3_ff   <= act2_ff;
      iw1_ff    <= iw1_in;
      ih1_ff    <= ih1_in;
      sum1_ff   <= sum1_in;
      sum2_ff   <= sum1_ff;
      inter2_ff <= inter2_in;
      inter3_ff <= inter2_ff;
      prod3_ff  <= prod3_in;
      if (reset) begin
         w1_ff.live  <= 1'b0;
         w2_ff.live  <= 1'b0;
         w3_ff.live  <= 1'b0;
         out_ff.live <= 1'b0;
      end else begin
         w1_ff  <= word_in;
         w2_ff  <= w1_ff;
         w3_ff  <= w2_ff;
         out_ff <= out_in;
      end
   end

   assign word_out = out_ff;

endmodule
`default_nettype wire

// File: rtl/core/gbs_ctrl.sv
// Sequencer: takes a box, sends it down the cell row, appends survivors, returns the result.
`default_nettype none
module gbs_ctrl #(
   parameter int MAX_KEPT = 64,
   parameter int CNT_W    = 7,
   parameter int IDX_W    = 6
) (
   input  wire                          clock,
   input  wire                          reset,
   gbs_req_if.sink                      req_bus,
   gbs_rsp_if.source                    rsp_bus,
   gbs_csr_if.sink                      csr_bus,
   output logic [gbs_pkg::THR_W-1:0]    thr,
   output logic [CNT_W-1:0]             count,
   output gbs_pkg::wr_type              wr,
   output logic [IDX_W-1:0]             wr_idx,
   output gbs_pkg::word_type            head,
   input  gbs_pkg::word_type            tail
);

   gbs_pkg::state_type            state_ff, state_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [gbs_pkg::THR_W-1:0]     thr_ff;
   gbs_pkg::word_type             head_ff, head_in;
   gbs_pkg::word_type             hold_ff;
   logic                          rsp_valid_ff;
   logic                          keep_ff, overflow_ff;
   logic [gbs_pkg::COUNT_W-1:0]   kept_count_ff;

   logic accept, out_free, finish, full, store;

   assign accept   = req_bus.valid & req_bus.ready;
   assign out_free = ~rsp_valid_ff | rsp_bus.ready;
   assign full     = count_ff >= CNT_W'(MAX_KEPT);
   assign store    = ~hold_ff.sup & ~full;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gbs_pkg::ST_IDLE: if (accept)     state_in = gbs_pkg::ST_RUN;
         gbs_pkg::ST_RUN:  if (tail.live)  state_in = gbs_pkg::ST_DONE;
         gbs_pkg::ST_DONE: if (out_free)   state_in = gbs_pkg::ST_IDLE;
         default:                          state_in = gbs_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_bus.ready = 1'b0;
      finish        = 1'b0;
      case (state_ff)
         gbs_pkg::ST_IDLE: req_bus.ready = 1'b1;
         gbs_pkg::ST_RUN:  ;
         gbs_pkg::ST_DONE: finish = out_free;
         default:          ;
      endcase
   end

   always_comb begin
      head_in.live       = accept;
      head_in.sup        = 1'b0;
      head_in.box.x      = req_bus.box_x;
      head_in.box.y      = req_bus.box_y;
      head_in.box.width  = req_bus.box_width;
      head_in.box.height = req_bus.box_height;
      head_in.area       = gbs_pkg::AREA_W'(req_bus.box_width)
                           * gbs_pkg::AREA_W'(req_bus.box_height);
      count_in = count_ff;
      if (accept && req_bus.first_of_frame) begin
         count_in = '0;
      end else if (finish && store) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == gbs_pkg::ST_RUN && tail.live) begin
         hold_ff <= tail;
      end
      if (finish) begin
         keep_ff       <= ~hold_ff.sup;
         overflow_ff   <= ~hold_ff.sup & full;
         kept_count_ff <= gbs_pkg::COUNT_W'(count_in);
      end
      if (reset) begin
         state_ff     <= gbs_pkg::ST_IDLE;
         count_ff     <= '0;
         thr_ff       <= gbs_pkg::THR_RESET;
         rsp_valid_ff <= 1'b0;
         head_ff.live <= 1'b0;
      end else begin
         head_ff  <= head_in;
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_bus.valid) begin
            thr_ff <= csr_bus.iou_threshold;
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign csr_bus.ready      = 1'b1;
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.keep       = keep_ff;
   assign rsp_bus.overflow   = overflow_ff;
   assign rsp_bus.kept_count = kept_count_ff;

   assign thr     = thr_ff;
   assign count   = count_ff;
   assign head    = head_ff;
   assign wr.en   = finish & store;
   assign wr.box  = hold_ff.box;
   assign wr.area = hold_ff.area;
   assign wr_idx  = count_ff[IDX_W-1:0];

endmodule
`default_nettype wire

// File: rtl/core/greedy_box_suppression_top.sv
// Top level of greedy box suppression: sequencer and row of kept-box cells.
//
// Boxes arrive sorted by falling score; each is tested against every kept box
// and suppressed when inter * 2^THRESH_FRAC_BITS > iou_threshold * union. A
// surviving box is stored in the next free cell, or reported with overflow set
// when all MAX_KEPT cells are taken. first_of_frame empties the list before the
// box is tested. One box is in flight at a time: it walks the row of MAX_KEPT
// cells, and the next box is accepted only once its result has been registered.
// The result sits in an output register, and the next box is accepted while
// that word waits. iou_threshold is to be written through the csr channel only
// while no box is in flight; the block does not enforce this. It resets to 128.
`default_nettype none
module greedy_box_suppression_top #(
   parameter int MAX_KEPT         = 64,
   parameter int THRESH_FRAC_BITS = 8
) (
   input  wire          clock,
   input  wire          reset,
   gbs_req_if.sink      req_bus,
   gbs_rsp_if.source    rsp_bus,
   gbs_csr_if.sink      csr_bus
);

   localparam int CNT_W = $clog2(MAX_KEPT + 1);
   localparam int IDX_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

   logic [gbs_pkg::THR_W-1:0]  thr;
   logic [CNT_W-1:0]           count;
   gbs_pkg::wr_type            wr;
   logic [IDX_W-1:0]           wr_idx;
   gbs_pkg::word_type          link [MAX_KEPT+1];

   gbs_ctrl #(
      .MAX_KEPT (MAX_KEPT),
      .CNT_W    (CNT_W),
      .IDX_W    (IDX_W)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus),
      .thr     (thr),
      .count   (count),
      .wr      (wr),
      .wr_idx  (wr_idx),
      .head    (link[0]),
      .tail    (link[MAX_KEPT])
   );

   for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
      gbs_cell #(
         .INDEX (i),
         .CNT_W (CNT_W),
         .IDX_W (IDX_W),
         .FRAC  (THRESH_FRAC_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .thr      (thr),
         .count    (count),
         .wr       (wr),
         .wr_idx   (wr_idx),
         .word_in  (link[i]),
         .word_out (link[i+1])
      );
   end

endmodule
`default_nettype wire

// File: verif/tb_top.sv
// Testbench for greedy box suppression: directed and random frames against a kept-list model.
`timescale 1ns / 1ps

module tb_top;

   localparam int MAX_KEPT    = 64;
   localparam int FRAC_BITS   = 8;
   localparam int BOX_CYCLES  = 4 * MAX_KEPT + 3;
   localparam int IDLE_LIMIT  = 20000;
   localparam int LONG_HOLD   = 3000;
   localparam int HOLD_AT     = 300;
   localparam int PHASE_ITEMS = 222;

   typedef struct {
      logic             first;
      gbs_pkg::box_type box;
   } box_req_type;

   typedef struct packed {
      logic                        keep;
      logic [gbs_pkg::COUNT_W-1:0] kept_count;
      logic                        overflow;
   } verdict_type;

   typedef enum {FRAME_CLUSTER, FRAME_GRID, FRAME_WILD} frame_kind_type;

   logic clock = 1'b0;
   logic reset;

   gbs_req_if req_bus ();
   gbs_rsp_if rsp_bus ();
   gbs_csr_if csr_bus ();

   greedy_box_suppression_top #(
      .MAX_KEPT(MAX_KEPT),
      .THRESH_FRAC_BITS(FRAC_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   always #10 clock = ~clock;

   // predictor state
   gbs_pkg::box_type           survivor_box [MAX_KEPT];
   logic [gbs_pkg::AREA_W-1:0] survivor_area [MAX_KEPT];
   int                         survivor_count = 0;
   logic [gbs_pkg::THR_W-1:0]  iou_limit = gbs_pkg::THR_RESET;

   box_req_type pending_boxes [$];
   verdict_type expected_verdicts [$];

   int  error_count = 0;
   int  boxes_sent = 0;
   int  results_seen = 0;
   int  frames_seen = 0;
   int  suppressed_seen = 0;
   int  overflow_seen = 0;
   int  idle_cycles = 0;
   int  send_gap = 0;
   int  recv_gap = 0;
   int  hold_left = 0;
   bit  held_once = 1'b0;
   bit  idle_enabled = 1'b1;
   verdict_type got, want, predicted;

   function automatic longint shared_area(input gbs_pkg::box_type a,
                                          input gbs_pkg::box_type b);
      longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1, iw, ih;
      ax0 = longint'($signed(a.x));
      ay0 = longint'($signed(a.y));
      ax1 = ax0 + longint'({1'b0, a.width});
      ay1 = ay0 + longint'({1'b0, a.height});
      bx0 = longint'($signed(b.x));
      by0 = longint'($signed(b.y));
      bx1 = bx0 + longint'({1'b0, b.width});
      by1 = by0 + longint'({1'b0, b.height});
      if (ax0 > bx1 || ax1 < bx0 || ay0 > by1 || ay1 < by0)
         return 0;
      iw = ((ax1 < bx1) ? ax1 : bx1) - ((ax0 > bx0) ? ax0 : bx0);
      ih = ((ay1 < by1) ? ay1 : by1) - ((ay0 > by0) ? ay0 : by0);
      if (iw <= 0 || ih <= 0)
         return 0;
      return iw * ih;
   endfunction

   function automatic verdict_type screen_box(input box_req_type r);
      verdict_type v;
      longint      area, inter, uni;
      if (r.first)
         survivor_count = 0;
      area = longint'({1'b0, r.box.width}) * longint'({1'b0, r.box.height});
      v.keep = 1'b1;
      v.overflow = 1'b0;
      for (int i = 0; i < survivor_count; i++) begin
         inter = shared_area(r.box, survivor_box[i]);
         uni = area + longint'({1'b0, survivor_area[i]}) - inter;
         if ((inter << FRAC_BITS) > longint'({1'b0, iou_limit}) * uni)
            v.keep = 1'b0;
      end
      if (v.keep) begin
         if (survivor_count < MAX_KEPT) begin
            survivor_box[survivor_count] = r.box;
            survivor_area[survivor_count] = area[gbs_pkg::AREA_W-1:0];
            survivor_count++;
         end else begin
            v.overflow = 1'b1;
         end
      end
      v.kept_count = gbs_pkg::COUNT_W'(survivor_count);
      return v;
   endfunction

   function automatic int pick_gap(input int long_max);
      int r;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 20);
      return $urandom_range(50, long_max);
   endfunction

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.first_of_frame <= 1'b0;
         req_bus.box_x <= '0;
         req_bus.box_y <= '0;
         req_bus.box_width <= '0;
         req_bus.box_height <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predicted = screen_box(pending_boxes[0]);
            expected_verdicts = {expected_verdicts, predicted};
            if (pending_boxes[0].first)
               frames_seen++;
            if (!predicted.keep)
               suppressed_seen++;
            if (predicted.overflow)
               overflow_seen++;
            void'(pending_boxes.pop_front());
            boxes_sent++;
            send_gap = idle_enabled ? pick_gap(300) : 0;
            if (send_gap > 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (pending_boxes.size() > 0) begin
               req_bus.valid <= 1'b1;
               req_bus.first_of_frame <= pending_boxes[0].first;
               req_bus.box_x <= pending_boxes[0].box.x;
               req_bus.box_y <= pending_boxes[0].box.y;
               req_bus.box_width <= pending_boxes[0].box.width;
               req_bus.box_height <= pending_boxes[0].box.height;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end else if (!req_bus.valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_boxes.size() > 0) begin
               req_bus.valid <= 1'b1;
               req_bus.first_of_frame <= pending_boxes[0].first;
               req_bus.box_x <= pending_boxes[0].box.x;
               req_bus.box_y <= pending_boxes[0].box.y;
               req_bus.box_width <= pending_boxes[0].box.width;
               req_bus.box_height <= pending_boxes[0].box.height;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.keep = rsp_bus.keep;
            got.kept_count = rsp_bus.kept_count;
            got.overflow = rsp_bus.overflow;
            results_seen++;
            if (expected_verdicts.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result keep=%0b kept_count=%0d overflow=%0b",
                        $time, got.keep, got.kept_count, got.overflow);
            end else begin
               want = expected_verdicts.pop_front();
               if (got.keep !== want.keep) begin
                  error_count++;
                  $display("%0t: keep expected %0b actual %0b", $time, want.keep, got.keep);
               end
               if (got.kept_count !== want.kept_count) begin
                  error_count++;
                  $display("%0t: kept_count expected %0d actual %0d",
                           $time, want.kept_count, got.kept_count);
               end
               if (got.overflow !== want.overflow) begin
                  error_count++;
                  $display("%0t: overflow expected %0b actual %0b",
                           $time, want.overflow, got.overflow);
               end
            end
            recv_gap = idle_enabled ? pick_gap(100) : 0;
         end
         if (results_seen == HOLD_AT && !held_once) begin
            held_once = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT)
         @(posedge clock);
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("** greedy_box_suppression_top: FAILED **");
      $finish;
   end

   task automatic push_box(input bit first, input int x, input int y, input int w, input int h);
      box_req_type r;
      r.first = first;
      r.box.x = gbs_pkg::COORD_W'(x);
      r.box.y = gbs_pkg::COORD_W'(y);
      r.box.width = gbs_pkg::SIZE_W'(w);
      r.box.height = gbs_pkg::SIZE_W'(h);
      pending_boxes = {pending_boxes, r};
   endtask

   task automatic drain();
      while (pending_boxes.size() != 0 || expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [gbs_pkg::THR_W-1:0] value);
      csr_bus.iou_threshold <= value;
      csr_bus.valid <= 1'b1;
      @(posedge clock);
      while (!csr_bus.ready)
         @(posedge clock);
      iou_limit = value;
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic push_frame(input frame_kind_type kind);
      int n, cx [4], cy [4], cw [4], ch [4], centers, c, t, stride, x0, y0, w, h;
      bit first;
      first = ($urandom_range(0, 9) != 0);
      case (kind)
         FRAME_CLUSTER: begin
            n = $urandom_range(1, 40);
            centers = $urandom_range(1, 4);
            for (int k = 0; k < 4; k++) begin
               cx[k] = $urandom_range(0, 40000) - 20000;
               cy[k] = $urandom_range(0, 40000) - 20000;
               cw[k] = $urandom_range(16, 600);
               ch[k] = $urandom_range(16, 600);
            end
            for (int i = 0; i < n; i++) begin
               c = $urandom_range(0, centers - 1);
               w = cw[c] + $urandom_range(0, 40) - 20;
               h = ch[c] + $urandom_range(0, 40) - 20;
               push_box(first, cx[c] + $urandom_range(0, 64) - 32,
                        cy[c] + $urandom_range(0, 64) - 32, w, h);
               first = ($urandom_range(0, 99) < 3);
            end
         end
         FRAME_GRID: begin
            n = $urandom_range(66, 80);
            t = $urandom_range(0, 64);
            stride = ($urandom_range(0, 1) != 0) ? t : t + $urandom_range(1, 8);
            if (stride == 0)
               stride = 1;
            x0 = $urandom_range(0, 40000) - 20000;
            y0 = $urandom_range(0, 40000) - 20000;
            for (int i = 0; i < n; i++) begin
               push_box(first, x0 + (i % 10) * stride, y0 + (i / 10) * stride, t, t);
               first = ($urandom_range(0, 99) < 2);
            end
         end
         default: begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++) begin
               push_box(first, $urandom, $urandom, $urandom, $urandom);
               first = $urandom_range(0, 1);
            end
         end
      endcase
   endtask

   task automatic push_random_phase(input int items);
      int r, start;
      start = pending_boxes.size();
      while (pending_boxes.size() - start < items) begin
         r = $urandom_range(0, 99);
         if (r < 65)
            push_frame(FRAME_CLUSTER);
         else if (r < 82)
            push_frame(FRAME_GRID);
         else
            push_frame(FRAME_WILD);
      end
   endtask

   initial begin
      logic [gbs_pkg::THR_W-1:0] phase_thr [8];
      phase_thr = '{9'd0, 9'd256, 9'd511, 9'd1, 9'd77, 9'd192, 9'd300, 9'd128};
      phase_thr[7] = gbs_pkg::THR_W'($urandom_range(0, 256));
      reset = 1'b1;
      csr_bus.valid = 1'b0;
      csr_bus.iou_threshold = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset threshold: identical, touching, disjoint, zero-area, exact-boundary
      push_box(1, 0, 0, 100, 100);
      push_box(0, 0, 0, 100, 100);
      push_box(0, 100, 0, 100, 100);
      push_box(0, 300, 0, 100, 100);
      push_box(0, 50, 50, 0, 0);
      push_box(0, 50, 50, 0, 0);
      push_box(0, 50, 0, 100, 100);
      push_box(1, -32768, -32768, 32767, 32767);
      push_box(0, 32767, 32767, 32767, 32767);
      push_box(0, -1, -1, 32767, 32767);
      push_box(0, -16384, -16384, 32767, 32767);
      push_box(0, -32768, -32768, 32767, 32767);
      push_box(0, 0, 0, 32767, 0);
      push_box(1, 0, 0, 1000, 1000);
      push_box(0, 100, 100, 100, 100);
      push_box(1, 0, 0, 100, 100);
      push_box(0, 0, 0, 100, 50);
      push_box(0, 0, 0, 100, 51);
      push_box(1, 0, 0, 0, 0);
      push_box(0, 0, 0, 0, 0);
      push_box(0, 5000, -5000, 200, 300);
      drain();

      for (int p = 0; p < 8; p++) begin
         write_threshold(phase_thr[p]);
         idle_enabled = (p != 4);
         push_random_phase(PHASE_ITEMS);
         drain();
      end

      repeat (2 * BOX_CYCLES) @(posedge clock);
      $display("Sent %0d boxes in %0d frames over 9 threshold settings (0 to 511).",
               boxes_sent, frames_seen);
      $display("Saw %0d suppressed and %0d overflow results, %0d mismatches.",
               suppressed_seen, overflow_seen, error_count);
      if (error_count == 0 && expected_verdicts.size() == 0)
         $display("** greedy_box_suppression_top: PASSED **");
      else
         $display("** greedy_box_suppression_top: FAILED **");
      $finish;
   end

endmodule
